[rtl/msp_pkg.sv]
// ----------------------------------------------------------------------------
// msp_pkg
// shared constants, widths and types for the midi stream parser
// ----------------------------------------------------------------------------
package msp_pkg;

    localparam int FRAME_CAPACITY = 256;
    localparam int FILL_W         = $clog2(FRAME_CAPACITY + 1);
    localparam int ADDR_W         = $clog2(FRAME_CAPACITY);

    // input action codes
    localparam logic ACT_FEED = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // status byte codes
    localparam logic [7:0] ST_SYSEX_START = 8'hF0;
    localparam logic [7:0] ST_SYSEX_END   = 8'hF7;
    localparam logic [7:0] ST_SYS_MIN     = 8'hF1;
    localparam logic [7:0] ST_SYS_MAX     = 8'hF6;
    localparam logic [7:0] ST_REALTIME    = 8'hF8;

    // message kinds; program and pressure carry a single data byte
    localparam logic [3:0] KIND_PROGRAM  = 4'hC;
    localparam logic [3:0] KIND_PRESSURE = 4'hD;
    localparam logic [3:0] KIND_NOTE_OFF = 4'h8;

    localparam logic [15:0] TALLY_MAX = 16'hFFFF;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } mem_wr_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [3:0]  channel;
        logic [6:0]  first;
        logic [6:0]  second;
        logic [31:0] stamp;
        logic        ready;
        logic [8:0]  length;
        logic [15:0] tally;
    } parse_stat_t;

endpackage

[rtl/midi_stream_parser_with_sysex_top.sv]
// ----------------------------------------------------------------------------
// midi_stream_parser_with_sysex_top
// midi running status parser with sysex frame capture and readback
// ----------------------------------------------------------------------------
// input channel: in_valid / in_stall carry one beat of action, wire_byte,
//   arrival_time and read_index. action 0 feeds a wire byte, action 1 reads
//   one byte of the stored sysex frame at read_index.
// output channel: out_valid / out_stall carry exactly one result beat per
//   input beat, in order.
// a taken beat passes through one input register and then the parser state
//   registers that double as the result register. throughput: one beat per
//   cycle while the result is not stalled.
// the frame buffer is a 256 x 8 memory; readback data comes from its
//   registered read port, written and read in the same pass.
// when out_stall is high over a valid result, that result holds, the input
//   register keeps its beat, and in_stall rises only while it is full and blocked.
// reset clears running status, held message, frame state and the oversize
//   tally; buffer contents stay undefined until written.
// ----------------------------------------------------------------------------
module midi_stream_parser_with_sysex_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [7:0]  wire_byte,
    input  logic [31:0] arrival_time,
    input  logic [7:0]  read_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        message_valid,
    output logic [3:0]  message_kind,
    output logic [3:0]  message_channel,
    output logic [6:0]  first_data,
    output logic [6:0]  second_data,
    output logic [31:0] message_time,
    output logic        frame_ready,
    output logic [8:0]  frame_length,
    output logic [15:0] oversized_count,
    output logic [7:0]  read_byte
);
    import msp_pkg::*;

    logic        in_valid_reg;
    logic        act_reg;
    logic [7:0]  byte_reg;
    logic [31:0] stamp_reg;
    logic [7:0]  idx_reg;
    logic        out_valid_reg;
    logic        msg_valid_reg;
    logic        rd_sel_reg;
    logic        adv;
    logic        msg_done;
    logic [7:0]  rd_data;
    mem_wr_t     mem_wr;
    parse_stat_t stat;

    // the pass moves forward when the result slot is empty or being taken
    assign adv      = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            act_reg   <= action;
            byte_reg  <= wire_byte;
            stamp_reg <= arrival_time;
            idx_reg   <= read_index;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            msg_valid_reg <= 1'b0;
            rd_sel_reg    <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= 1'b1;
            msg_valid_reg <= msg_done;
            rd_sel_reg    <= (act_reg == ACT_READ)
                             && (32'(idx_reg) < 32'(FRAME_CAPACITY));
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    msp_parse u_parse (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (adv),
        .act      (act_reg),
        .byte_in  (byte_reg),
        .stamp_in (stamp_reg),
        .msg_done (msg_done),
        .mem_wr   (mem_wr),
        .stat     (stat)
    );

    msp_frame_mem u_mem (
        .clk     (clk),
        .wr      (mem_wr),
        .rd_en   (adv),
        .rd_addr (ADDR_W'(idx_reg)),
        .rd_data (rd_data)
    );

    assign out_valid       = out_valid_reg;
    assign message_valid   = msg_valid_reg;
    assign message_kind    = stat.kind;
    assign message_channel = stat.channel;
    assign first_data      = stat.first;
    assign second_data     = stat.second;
    assign message_time    = stat.stamp;
    assign frame_ready     = stat.ready;
    assign frame_length    = stat.length;
    assign oversized_count = stat.tally;
    assign read_byte       = rd_sel_reg ? rd_data : 8'd0;

    a_msg_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && msg_valid_reg) |-> stat.kind >= KIND_NOTE_OFF)
        else $error("completed message without channel kind");

    a_msg_not_read: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && msg_valid_reg) |-> !rd_sel_reg)
        else $error("message and readback in one result");

    a_no_step_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !adv)
        else $error("pass advanced over a stalled result");

endmodule

[rtl/msp_frame_mem.sv]
// ----------------------------------------------------------------------------
// msp_frame_mem
// sysex frame buffer, one write port and one registered read port
// ----------------------------------------------------------------------------
module msp_frame_mem (
    input  logic                      clk,
    input  msp_pkg::mem_wr_t          wr,
    input  logic                      rd_en,
    input  logic [msp_pkg::ADDR_W-1:0] rd_addr,
    output logic [7:0]                rd_data
);
    import msp_pkg::*;

    logic [7:0] mem [FRAME_CAPACITY];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // read data holds while the result is stalled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/msp_parse.sv]
// ----------------------------------------------------------------------------
// msp_parse
// running status decode, message hold registers and sysex capture control
// ----------------------------------------------------------------------------
module msp_parse (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic                 act,
    input  logic [7:0]           byte_in,
    input  logic [31:0]          stamp_in,
    output logic                 msg_done,
    output msp_pkg::mem_wr_t     mem_wr,
    output msp_pkg::parse_stat_t stat
);
    import msp_pkg::*;

    logic [7:0]        rs_reg,      rs_next;
    logic              dpos_reg,    dpos_next;
    logic [1:0]        expct_reg,   expct_next;
    logic              in_frame_reg, in_frame_next;
    logic              ovf_reg,     ovf_next;
    logic              done_reg,    done_next;
    logic [FILL_W-1:0] fill_reg,    fill_next;
    logic [15:0]       tally_reg,   tally_next;
    logic [3:0]        kind_reg,    kind_next;
    logic [3:0]        chan_reg,    chan_next;
    logic [6:0]        first_reg,   first_next;
    logic [6:0]        second_reg,  second_next;
    logic [31:0]       stamp_reg,   stamp_next;
    mem_wr_t           wr;
    logic              valid;

    always_comb
    begin
        rs_next       = rs_reg;
        dpos_next     = dpos_reg;
        expct_next    = expct_reg;
        in_frame_next = in_frame_reg;
        ovf_next      = ovf_reg;
        done_next     = done_reg;
        fill_next     = fill_reg;
        tally_next    = tally_reg;
        kind_next     = kind_reg;
        chan_next     = chan_reg;
        first_next    = first_reg;
        second_next   = second_reg;
        stamp_next    = stamp_reg;
        wr.en         = 1'b0;
        wr.addr       = fill_reg[ADDR_W-1:0];
        wr.data       = byte_in;
        valid         = 1'b0;

        if (act == ACT_FEED && byte_in < ST_REALTIME)
        begin
            if (byte_in[7])
            begin
                if (byte_in == ST_SYSEX_START)
                begin
                    in_frame_next = 1'b1;
                    rs_next       = 8'd0;
                    done_next     = 1'b0;
                    ovf_next      = 1'b0;
                    wr.en         = 1'b1;
                    wr.addr       = '0;
                    fill_next     = FILL_W'(1);
                end
                else if (byte_in == ST_SYSEX_END)
                begin
                    if (in_frame_reg)
                    begin
                        if (ovf_reg || fill_reg >= FILL_W'(FRAME_CAPACITY))
                        begin
                            if (tally_reg != TALLY_MAX)
                            begin
                                tally_next = tally_reg + 16'd1;
                            end
                            fill_next = '0;
                        end
                        else
                        begin
                            wr.en     = 1'b1;
                            fill_next = fill_reg + FILL_W'(1);
                            done_next = 1'b1;
                        end
                    end
                    in_frame_next = 1'b0;
                    ovf_next      = 1'b0;
                end
                else
                begin
                    // any other status aborts a capture in progress
                    if (in_frame_reg)
                    begin
                        in_frame_next = 1'b0;
                        fill_next     = '0;
                        ovf_next      = 1'b0;
                    end
                    if (byte_in >= ST_SYS_MIN && byte_in <= ST_SYS_MAX)
                    begin
                        rs_next = 8'd0;
                    end
                    else
                    begin
                        rs_next   = byte_in;
                        dpos_next = 1'b0;
                        if (byte_in[7:4] == KIND_PROGRAM || byte_in[7:4] == KIND_PRESSURE)
                        begin
                            expct_next = 2'd1;
                        end
                        else
                        begin
                            expct_next = 2'd2;
                        end
                        kind_next = byte_in[7:4];
                        chan_next = byte_in[3:0];
                    end
                end
            end
            else if (in_frame_reg)
            begin
                if (!ovf_reg)
                begin
                    if (fill_reg < FILL_W'(FRAME_CAPACITY - 1))
                    begin
                        wr.en     = 1'b1;
                        fill_next = fill_reg + FILL_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
            else if (rs_reg != 8'd0)
            begin
                if (!dpos_reg)
                begin
                    kind_next  = rs_reg[7:4];
                    chan_next  = rs_reg[3:0];
                    stamp_next = stamp_in;
                    first_next = byte_in[6:0];
                    if (expct_reg == 2'd1)
                    begin
                        second_next = 7'd0;
                        dpos_next   = 1'b0;
                        valid       = 1'b1;
                    end
                    else
                    begin
                        dpos_next = 1'b1;
                    end
                end
                else
                begin
                    second_next = byte_in[6:0];
                    dpos_next   = 1'b0;
                    valid       = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rs_reg       <= '0;
            dpos_reg     <= 1'b0;
            expct_reg    <= '0;
            in_frame_reg <= 1'b0;
            ovf_reg      <= 1'b0;
            done_reg     <= 1'b0;
            fill_reg     <= '0;
            tally_reg    <= '0;
            kind_reg     <= '0;
            chan_reg     <= '0;
            first_reg    <= '0;
            second_reg   <= '0;
            stamp_reg    <= '0;
        end
        else if (step)
        begin
            rs_reg       <= rs_next;
            dpos_reg     <= dpos_next;
            expct_reg    <= expct_next;
            in_frame_reg <= in_frame_next;
            ovf_reg      <= ovf_next;
            done_reg     <= done_next;
            fill_reg     <= fill_next;
            tally_reg    <= tally_next;
            kind_reg     <= kind_next;
            chan_reg     <= chan_next;
            first_reg    <= first_next;
            second_reg   <= second_next;
            stamp_reg    <= stamp_next;
        end
    end

    assign msg_done = valid;

    always_comb
    begin
        mem_wr    = wr;
        mem_wr.en = wr.en && step;
    end

    assign stat.kind    = kind_reg;
    assign stat.channel = chan_reg;
    assign stat.first   = first_reg;
    assign stat.second  = second_reg;
    assign stat.stamp   = stamp_reg;
    assign stat.ready   = done_reg;
    assign stat.length  = 9'(fill_reg);
    assign stat.tally   = tally_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(FRAME_CAPACITY))
        else $error("frame fill beyond capacity");

    a_done_closed: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !in_frame_reg)
        else $error("frame marked complete while capturing");

    a_ovf_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> in_frame_reg)
        else $error("overflow mark outside a frame");

    a_rs_channel: assert property (@(posedge clk) disable iff (!rst_n)
        rs_reg != 8'd0 |-> (rs_reg[7] && rs_reg < ST_SYSEX_START
                            && (expct_reg == 2'd1 || expct_reg == 2'd2)))
        else $error("running status is not a channel status");

endmodule
